/* design/spq_pkg.sv */
// Package for the stable priority ready queue.
// Holds the cell control struct and the fixed codes and widths; no dependencies.
package spq_pkg;

  localparam int HELD_W = 5;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef struct packed {
    logic ins;
    logic pop;
  } spq_ctl_t;

endpackage

/* design/spq_if.sv */
// Valid/ready channel interfaces for the queue: request in, result out.
// Depends on spq_pkg for the entries_held width.
interface spq_in_if #(
  parameter int ID_BITS       = 6,
  parameter int PRIORITY_BITS = 8
);
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [ID_BITS-1:0]       task_id;
  logic [PRIORITY_BITS-1:0] task_priority;

  modport source (output valid, kind, task_id, task_priority, input ready);
  modport sink   (input valid, kind, task_id, task_priority, output ready);
endinterface

interface spq_out_if #(
  parameter int ID_BITS       = 6,
  parameter int PRIORITY_BITS = 8
);
  logic                        valid;
  logic                        ready;
  logic                        popped_valid;
  logic [ID_BITS-1:0]          popped_task_id;
  logic [PRIORITY_BITS-1:0]    popped_priority;
  logic                        rejected;
  logic [spq_pkg::HELD_W-1:0]  entries_held;

  modport source (output valid, popped_valid, popped_task_id, popped_priority, rejected,
                  entries_held, input ready);
  modport sink   (input valid, popped_valid, popped_task_id, popped_priority, rejected,
                  entries_held, output ready);
endinterface

/* design/spq_cell.sv */
// One slot of the sorted chain: holds a task and its priority, shifts with neighbors.
// Depends on spq_pkg for the control struct.
module spq_cell #(
  parameter int ID_BITS       = 6,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                     clk,
  input  spq_pkg::spq_ctl_t        ctl,
  input  logic                     is_valid,
  input  logic [ID_BITS-1:0]       new_id,
  input  logic [PRIORITY_BITS-1:0] new_pri,
  input  logic                     prev_lower,
  input  logic [ID_BITS-1:0]       prev_id,
  input  logic [PRIORITY_BITS-1:0] prev_pri,
  input  logic [ID_BITS-1:0]       next_id,
  input  logic [PRIORITY_BITS-1:0] next_pri,
  output logic                     lower,
  output logic [ID_BITS-1:0]       id,
  output logic [PRIORITY_BITS-1:0] pri
);
  import spq_pkg::*;

  logic [ID_BITS-1:0]       id_r,  id_nxt;
  logic [PRIORITY_BITS-1:0] pri_r, pri_nxt;

  // empty slot or strictly lower priority: new task goes at or before here
  assign lower = !is_valid || (new_pri > pri_r);

  always_comb begin
    id_nxt  = id_r;
    pri_nxt = pri_r;
    if (ctl.pop) begin
      id_nxt  = next_id;
      pri_nxt = next_pri;
    end else if (ctl.ins && lower) begin
      if (prev_lower) begin
        id_nxt  = prev_id;
        pri_nxt = prev_pri;
      end else begin
        id_nxt  = new_id;
        pri_nxt = new_pri;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    pri_r <= pri_nxt;
  end

  assign id  = id_r;
  assign pri = pri_r;

endmodule

/* design/stable_priority_ready_queue_top.sv */
// Top level of the stable priority ready queue: chain of spq_cell slots,
// occupancy counter and result register. Depends on spq_pkg, spq_if, spq_cell.
//
//  channel | dir | payload                                               | transfer
//  in_ch   | in  | kind, task_id, task_priority                          | valid && ready
//  out_ch  | out | popped_valid, popped_task_id, popped_priority,        | valid && ready
//          |     | rejected, entries_held                                |
//
// One item per cycle unless a result waits on a low out_ch.ready; its result appears the cycle after the transfer.
// All slots compare against the new priority at once and shift together.
// Reset (rst_n low, synchronous) empties the queue and drops a pending result.
// in_ch.ready falls only while a result waits and out_ch.ready is low.
module stable_priority_ready_queue_top #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int ID_BITS       = 6,
  parameter int PRIORITY_BITS = 8
) (
  input logic clk,
  input logic rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             out_valid_r;
  logic             accept, full, empty;
  spq_ctl_t         ctl;

  logic [ID_BITS-1:0]       id_w    [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] pri_w   [QUEUE_DEPTH];
  logic                     lower_w [QUEUE_DEPTH];

  logic                     pv_r;
  logic [ID_BITS-1:0]       pid_r;
  logic [PRIORITY_BITS-1:0] ppri_r;
  logic                     rej_r;
  logic [HELD_W-1:0]        held_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign empty       = (occ_r == '0);

  assign ctl.ins = accept && (in_ch.kind == KIND_ENQ) && !full;
  assign ctl.pop = accept && (in_ch.kind == KIND_DEQ) && !empty;

  always_comb begin
    occ_nxt = occ_r;
    if (ctl.ins) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (ctl.pop) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     pl;
    logic [ID_BITS-1:0]       pid, nid;
    logic [PRIORITY_BITS-1:0] ppr, npr;

    if (i == 0) begin : g_head
      assign pl  = 1'b0;
      assign pid = '0;
      assign ppr = '0;
    end else begin : g_body
      assign pl  = lower_w[i-1];
      assign pid = id_w[i-1];
      assign ppr = pri_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nid = '0;
      assign npr = '0;
    end else begin : g_mid
      assign nid = id_w[i+1];
      assign npr = pri_w[i+1];
    end

    spq_cell #(
      .ID_BITS       (ID_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .is_valid   (OCC_W'(i) < occ_r),
      .new_id     (in_ch.task_id),
      .new_pri    (in_ch.task_priority),
      .prev_lower (pl),
      .prev_id    (pid),
      .prev_pri   (ppr),
      .next_id    (nid),
      .next_pri   (npr),
      .lower      (lower_w[i]),
      .id         (id_w[i]),
      .pri        (pri_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pv_r   <= ctl.pop;
      pid_r  <= ctl.pop ? id_w[0]  : '0;
      ppri_r <= ctl.pop ? pri_w[0] : '0;
      rej_r  <= (in_ch.kind == KIND_ENQ) && full;
      held_r <= HELD_W'(occ_nxt);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.popped_valid    = pv_r;
  assign out_ch.popped_task_id  = pid_r;
  assign out_ch.popped_priority = ppri_r;
  assign out_ch.rejected        = rej_r;
  assign out_ch.entries_held    = held_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above capacity");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.kind == KIND_ENQ) && full) |=> (out_ch.valid && out_ch.rejected))
    else $error("enqueue into full queue not rejected");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.kind == KIND_DEQ) && !empty)
      |=> (out_ch.popped_valid && (occ_r == $past(occ_r) - OCC_W'(1))))
    else $error("dequeue did not remove the head");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r >= OCC_W'(2)) |-> (pri_w[0] >= pri_w[1]))
    else $error("head slot out of order");
`endif

endmodule

/* dv/tb_stable_priority_ready_queue_top.sv */
// Self-checking bench for stable_priority_ready_queue_top: a sorted mirror of the
// queue predicts every result, with random idling and stalls on both channels.
// Depends on spq_pkg, spq_if and the design sources.
module tb_stable_priority_ready_queue_top;
  import spq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int ID_W       = 6;
  localparam int PRI_W      = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 1800;

  typedef struct {
    logic             kind;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } request_t;

  typedef struct {
    logic              popped_valid;
    logic [ID_W-1:0]   popped_id;
    logic [PRI_W-1:0]  popped_pri;
    logic              rejected;
    logic [HELD_W-1:0] held;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  #(.ID_BITS(ID_W), .PRIORITY_BITS(PRI_W)) in_ch ();
  spq_out_if #(.ID_BITS(ID_W), .PRIORITY_BITS(PRI_W)) out_ch ();

  stable_priority_ready_queue_top #(
    .QUEUE_DEPTH  (DEPTH),
    .ID_BITS      (ID_W),
    .PRIORITY_BITS(PRI_W)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Sorted mirror of the queue contents, head at index 0
  logic [ID_W-1:0]  mirror_id  [DEPTH];
  logic [PRI_W-1:0] mirror_pri [DEPTH];
  int               mirror_count = 0;

  request_t pending_requests[$];
  result_t  awaited_results[$];

  int requests_queued  = 0;
  int requests_taken   = 0;
  int results_seen     = 0;
  int mismatches       = 0;
  int enq_count        = 0;
  int reject_count     = 0;
  int pop_count        = 0;
  int empty_pop_count  = 0;
  int peak_count       = 0;
  int send_gap         = 0;
  int hold_left        = 0;
  bit long_hold_done   = 1'b0;
  int idle_cycles      = 0;

  function automatic result_t serve_request(request_t r);
    result_t res;
    int      pos;
    res = '{default: '0};
    if (r.kind == KIND_ENQ) begin
      if (mirror_count >= DEPTH) begin
        res.rejected = 1'b1;
      end else begin
        pos = mirror_count;
        for (int i = mirror_count - 1; i >= 0; i--) begin
          if (r.pri > mirror_pri[i]) pos = i;
        end
        for (int i = mirror_count; i > pos; i--) begin
          mirror_id[i]  = mirror_id[i-1];
          mirror_pri[i] = mirror_pri[i-1];
        end
        mirror_id[pos]  = r.id;
        mirror_pri[pos] = r.pri;
        mirror_count++;
      end
    end else if (mirror_count > 0) begin
      res.popped_valid = 1'b1;
      res.popped_id    = mirror_id[0];
      res.popped_pri   = mirror_pri[0];
      for (int i = 1; i < mirror_count; i++) begin
        mirror_id[i-1]  = mirror_id[i];
        mirror_pri[i-1] = mirror_pri[i];
      end
      mirror_count--;
    end
    res.held = HELD_W'(mirror_count);
    return res;
  endfunction

  // pri_mode: 0 full range, 1 few values (many ties), 2 near the extremes
  function automatic request_t make_request(int enq_pct, int pri_mode);
    request_t r;
    r.kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
    r.id   = ID_W'($urandom_range(0, (1 << ID_W) - 1));
    case (pri_mode)
      1: r.pri = PRI_W'($urandom_range(0, 3) * 85);
      2: r.pri = $urandom_range(0, 1) ? PRI_W'($urandom_range(0, 1))
                                      : PRI_W'($urandom_range(254, 255));
      default: r.pri = PRI_W'($urandom_range(0, (1 << PRI_W) - 1));
    endcase
    return r;
  endfunction

  task automatic queue_request(logic kind, int id, int pri);
    request_t r;
    r.kind = kind;
    r.id   = ID_W'(id);
    r.pri  = PRI_W'(pri);
    pending_requests.push_back(r);
    requests_queued++;
  endtask

  task automatic wait_drained();
    while (requests_taken < requests_queued || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  // Driver
  always @(posedge clk) begin
    request_t r;
    int       pick;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        r.kind = in_ch.kind;
        r.id   = in_ch.task_id;
        r.pri  = in_ch.task_priority;
        awaited_results.push_back(serve_request(r));
        requests_taken++;
        if (r.kind == KIND_ENQ) begin
          enq_count++;
          if (awaited_results[$].rejected) reject_count++;
        end else begin
          pop_count++;
          if (!awaited_results[$].popped_valid) empty_pop_count++;
        end
        if (mirror_count > peak_count) peak_count = mirror_count;
        pick = $urandom_range(0, 99);
        if ((requests_taken / 150) % 4 == 3) send_gap = 0;
        else if (pick < 60) send_gap = 0;
        else if (pick < 90) send_gap = $urandom_range(1, 3);
        else if (pick < 97) send_gap = $urandom_range(4, 10);
        else send_gap = $urandom_range(20, 50);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          r = pending_requests.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.kind          <= r.kind;
          in_ch.task_id       <= r.id;
          in_ch.task_priority <= r.pri;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and result-side ready
  always @(posedge clk) begin
    result_t want;
    bit      bad;
    int      pick;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result valid=%0d id=%0d pri=%0d rej=%0d held=%0d",
                     out_ch.popped_valid, out_ch.popped_task_id, out_ch.popped_priority,
                     out_ch.rejected, out_ch.entries_held);
        end else begin
          want = awaited_results.pop_front();
          bad  = (out_ch.popped_valid    !== want.popped_valid) ||
                 (out_ch.popped_task_id  !== want.popped_id)    ||
                 (out_ch.popped_priority !== want.popped_pri)   ||
                 (out_ch.rejected        !== want.rejected)     ||
                 (out_ch.entries_held    !== want.held);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: result %0d expected valid=%0d id=%0d pri=%0d rej=%0d held=%0d",
                        " got valid=%0d id=%0d pri=%0d rej=%0d held=%0d"},
                       results_seen, want.popped_valid, want.popped_id, want.popped_pri,
                       want.rejected, want.held, out_ch.popped_valid, out_ch.popped_task_id,
                       out_ch.popped_priority, out_ch.rejected, out_ch.entries_held);
          end
        end
      end
      if (!long_hold_done && results_seen >= 500) begin
        long_hold_done = 1'b1;
        hold_left      = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if ((results_seen / 150) % 4 == 1 || pick < 75) begin
          out_ch.ready <= 1'b1;
        end else begin
          hold_left    = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
          out_ch.ready <= 1'b0;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int enq_pct;
    int pri_mode;
    int burst;
    int made;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_ENQ;
    in_ch.task_id       = '0;
    in_ch.task_priority = '0;
    out_ch.ready        = 1'b0;
    rst_n               = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // dequeue on empty, extremes, ties at head/middle/tail, fill, full, three dequeues
    queue_request(KIND_DEQ, 0, 0);
    queue_request(KIND_ENQ, 63, 255);
    queue_request(KIND_ENQ, 0, 0);
    queue_request(KIND_ENQ, 42, 255);
    queue_request(KIND_ENQ, 21, 0);
    queue_request(KIND_ENQ, 1, 128);
    queue_request(KIND_ENQ, 62, 128);
    for (int i = 0; i < 10; i++)
      queue_request(KIND_ENQ, 10 + i, (i % 2) ? 128 : i * 25);
    queue_request(KIND_ENQ, 33, 200);
    queue_request(KIND_DEQ, 63, 255);
    queue_request(KIND_DEQ, 0, 0);
    queue_request(KIND_DEQ, 42, 170);
    wait_drained();

    made = 0;
    while (made < RAND_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        default: enq_pct = 15;
      endcase
      pri_mode = $urandom_range(0, 2);
      burst    = $urandom_range(20, 80);
      for (int i = 0; i < burst && made < RAND_ITEMS; i++) begin
        pending_requests.push_back(make_request(enq_pct, pri_mode));
        requests_queued++;
        made++;
      end
      // sender holds off once until all queued requests have been answered
      if (made >= RAND_ITEMS / 2 && made - burst < RAND_ITEMS / 2) wait_drained();
    end
    wait_drained();
    repeat (10) @(posedge clk);

    if (awaited_results.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d results never arrived", awaited_results.size());
    end
    $display("Run covered %0d requests: %0d enqueues (%0d refused on a full queue), %0d dequeues",
             requests_taken, enq_count, reject_count, pop_count);
    $display("  %0d dequeues hit an empty queue; peak occupancy %0d of %0d; %0d bad results",
             empty_pop_count, peak_count, DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
